// ===== rtl/aass_pkg.sv =====
// shared types and constants for the adaptive average slope signal block
`timescale 1ns / 1ps
`default_nettype none
package aass_pkg;

	localparam int PRICE_WIDTH    = 32;
	localparam int MAX_WINDOW_DEF = 64;
	localparam int FRAC_W         = 24;
	localparam int LEVEL_W        = 48;
	localparam int CNT_W          = 11;
	localparam int PERIOD_W       = 10;
	localparam int WIN_CFG_W      = 7;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 10;
	localparam int SLOPE_W        = 33;
	localparam int VOL_W          = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FAST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMA    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_SWEEP,
		OP_DIV,
		OP_MAC
	} op_t;

	typedef enum logic [2:0] {
		SEL_ER,
		SEL_FAST,
		SEL_SLOW,
		SEL_RATE_EMA,
		SEL_SSC,
		SEL_C2,
		SEL_ADA,
		SEL_EMA
	} sel_t;

	typedef struct packed {
		logic load;
		logic finish;
		op_t  op;
		sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic last;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/adaptive_average_slope_signal.sv =====
// top level of the adaptive average slope signal block
//
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// in       | in_valid, in_ready  | price
// out      | out_valid,out_ready | average, slope, slope_valid, order_size
// cfg      | cfg_we              | cfg_index, cfg_data
//
// one price at a time; a warm-up price skips the sweep, divisions and blends
// and goes straight to the finish state; after warm-up the window sweep reads
// one ring entry a cycle, four 25-step divisions and four 6-step blends share
// one divider and one 24x25 multiplier
// a new price is taken while the previous result still waits at the output
// no clearing pass after reset; the ring is only read where already written
`timescale 1ns / 1ps
`default_nettype none
module adaptive_average_slope_signal #(
	parameter int MAX_WINDOW = aass_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [aass_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [aass_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [aass_pkg::PRICE_WIDTH-1:0]      price,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [aass_pkg::PRICE_WIDTH-1:0]           average,
	output logic signed [aass_pkg::SLOPE_W-1:0]        slope,
	output logic                                       slope_valid,
	output logic signed [aass_pkg::VOL_W-1:0]          order_size
);

	aass_pkg::cmd_t cmd;
	aass_pkg::sts_t sts;

	aass_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aass_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.price        (price),
		.cmd          (cmd),
		.sts          (sts),
		.average      (average),
		.slope        (slope),
		.slope_valid  (slope_valid),
		.order_size   (order_size)
	);

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_volume_needs_slope: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && order_size != 0 |-> slope_valid)
		else $error("order size without valid slope");

	a_invalid_slope_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !slope_valid |-> slope == 0 && order_size == 0)
		else $error("nonzero slope without valid flag");

endmodule
`default_nettype wire

// ===== rtl/aass_ctrl.sv =====
// sequencer for sweep, divisions, blends and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module aass_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire aass_pkg::sts_t sts,
	output aass_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SWEEP,
		S_DIV_ER,
		S_DIV_FAST,
		S_DIV_SLOW,
		S_DIV_EMA,
		S_MAC_SSC,
		S_MAC_C2,
		S_MAC_ADA,
		S_MAC_EMA,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.load   = in_valid && (state_q == S_IDLE);
		cmd.finish = (state_q == S_FINISH) && (!out_valid_q || out_ready);
		cmd.op     = aass_pkg::OP_NONE;
		cmd.sel    = aass_pkg::SEL_ER;
		unique case (state_q)
			S_SWEEP: cmd.op = aass_pkg::OP_SWEEP;
			S_DIV_ER: begin
				cmd.op  = aass_pkg::OP_DIV;
				cmd.sel = aass_pkg::SEL_ER;
			end
			S_DIV_FAST: begin
				cmd.op  = aass_pkg::OP_DIV;
				cmd.sel = aass_pkg::SEL_FAST;
			end
			S_DIV_SLOW: begin
				cmd.op  = aass_pkg::OP_DIV;
				cmd.sel = aass_pkg::SEL_SLOW;
			end
			S_DIV_EMA: begin
				cmd.op  = aass_pkg::OP_DIV;
				cmd.sel = aass_pkg::SEL_RATE_EMA;
			end
			S_MAC_SSC: begin
				cmd.op  = aass_pkg::OP_MAC;
				cmd.sel = aass_pkg::SEL_SSC;
			end
			S_MAC_C2: begin
				cmd.op  = aass_pkg::OP_MAC;
				cmd.sel = aass_pkg::SEL_C2;
			end
			S_MAC_ADA: begin
				cmd.op  = aass_pkg::OP_MAC;
				cmd.sel = aass_pkg::SEL_ADA;
			end
			S_MAC_EMA: begin
				cmd.op  = aass_pkg::OP_MAC;
				cmd.sel = aass_pkg::SEL_EMA;
			end
			default: cmd.op = aass_pkg::OP_NONE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= sts.active ? S_SWEEP : S_FINISH;
					end
				end
				S_SWEEP:    if (sts.last) state_q <= S_DIV_ER;
				S_DIV_ER:   if (sts.last) state_q <= S_DIV_FAST;
				S_DIV_FAST: if (sts.last) state_q <= S_DIV_SLOW;
				S_DIV_SLOW: if (sts.last) state_q <= S_DIV_EMA;
				S_DIV_EMA:  if (sts.last) state_q <= S_MAC_SSC;
				S_MAC_SSC:  if (sts.last) state_q <= S_MAC_C2;
				S_MAC_C2:   if (sts.last) state_q <= S_MAC_ADA;
				S_MAC_ADA:  if (sts.last) state_q <= S_MAC_EMA;
				S_MAC_EMA:  if (sts.last) state_q <= S_FINISH;
				S_FINISH: begin
					if (cmd.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/aass_dp.sv =====
// datapath: config registers, price ring, divider, multiply-accumulate, result registers
`timescale 1ns / 1ps
`default_nettype none
module aass_dp #(
	parameter int MAX_WINDOW = aass_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [aass_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [aass_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic [aass_pkg::PRICE_WIDTH-1:0]      price,
	input  wire aass_pkg::cmd_t                        cmd,
	output aass_pkg::sts_t                             sts,
	output logic [aass_pkg::PRICE_WIDTH-1:0]           average,
	output logic signed [aass_pkg::SLOPE_W-1:0]        slope,
	output logic                                       slope_valid,
	output logic signed [aass_pkg::VOL_W-1:0]          order_size
);

	localparam int PW        = aass_pkg::PRICE_WIDTH;
	localparam int FW        = aass_pkg::FRAC_W;
	localparam int LW        = aass_pkg::LEVEL_W;
	localparam int CW        = aass_pkg::CNT_W;
	localparam int DEPTH     = MAX_WINDOW + 2;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
	localparam int STEP_W    = (WIN_W > 5) ? WIN_W : 5;
	localparam int SUM_W     = PW + WIN_W;
	localparam int Q_W       = FW + 1;
	localparam int PROD_W    = FW + Q_W;
	localparam int ACC_W     = LW + 26;
	localparam int MAC_STEPS = 5;

	logic [aass_pkg::PERIOD_W-1:0]  fast_q, slow_q, emap_q;
	logic [aass_pkg::WIN_CFG_W-1:0] win_q;
	logic                           oen_q;

	logic [WIN_W-1:0]  w_eff;
	logic [CW-1:0]     count_q, idx_q, e_c;
	logic              active_q;
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PW-1:0]     mem [DEPTH];
	logic [PW-1:0]     rd_data_q, price_q, prev_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PW-1:0]     dir_q;
	logic [STEP_W-1:0] step_q;
	logic              rd_en, last;

	logic [aass_pkg::PERIOD_W-1:0] n_sel, n_eff, emap_eff;
	logic [CW-1:0]     np1;
	logic [SUM_W-1:0]  div_top, div_v, rem_q;
	logic [FW-1:0]     div_lo, lo_q;
	logic [Q_W-1:0]    quo_q, q_next;
	logic [SUM_W:0]    div_t;
	logic              ge0, ge;
	logic [Q_W-1:0]    er_q, fast_r_q, slow_r_q, ema_r_q, ssc_q, c2_q;

	logic [LW-1:0]     a_sel, b_sel;
	logic [Q_W-1:0]    w_sel, v_sel, mul_y;
	logic [FW-1:0]     mul_x;
	logic [PROD_W-1:0] prod_c, prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [LW-1:0]     mac_res;
	logic [LW-1:0]     ada_q, ema_q;

	logic [LW:0]       rnd;
	logic [PW-1:0]     avg_c, pavg_q;
	logic              have_q, show;
	logic signed [aass_pkg::SLOPE_W-1:0] slope_c, pslope_q;
	logic signed [aass_pkg::VOL_W-1:0]   vol_c;
	logic [PW-1:0]     sw_diff, dir_c;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= 10'd2;
			slow_q <= 10'd30;
			win_q  <= 7'd10;
			emap_q <= 10'd10;
			oen_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == aass_pkg::REG_FAST)   fast_q <= cfg_data;
			if (cfg_index == aass_pkg::REG_SLOW)   slow_q <= cfg_data;
			if (cfg_index == aass_pkg::REG_WINDOW) win_q  <= cfg_data[aass_pkg::WIN_CFG_W-1:0];
			if (cfg_index == aass_pkg::REG_EMA)    emap_q <= cfg_data;
			if (cfg_index == aass_pkg::REG_ORDER)  oen_q  <= cfg_data[0];
		end
	end

	always_comb begin
		if (win_q == '0) begin
			w_eff = WIN_W'(1);
		end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else begin
			w_eff = WIN_W'(win_q);
		end
	end

	assign sts.active = count_q >= CW'(w_eff);

	always_comb begin
		unique case (cmd.op)
			aass_pkg::OP_SWEEP: last = step_q == STEP_W'(w_eff);
			aass_pkg::OP_DIV:   last = step_q == STEP_W'(FW);
			aass_pkg::OP_MAC:   last = step_q == STEP_W'(MAC_STEPS);
			default:            last = 1'b0;
		endcase
	end
	assign sts.last = last;
	assign rd_en    = (cmd.op == aass_pkg::OP_SWEEP) && (step_q < STEP_W'(w_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.op != aass_pkg::OP_NONE) begin
			step_q <= last ? '0 : step_q + STEP_W'(1);
		end
	end

	// price ring
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wr_ptr_q] <= price;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	assign sw_diff = (prev_q > rd_data_q) ? prev_q - rd_data_q : rd_data_q - prev_q;
	assign dir_c   = (price_q > rd_data_q) ? price_q - rd_data_q : rd_data_q - price_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			active_q <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			sum_q    <= '0;
		end else begin
			if (cmd.load) begin
				idx_q    <= count_q;
				count_q  <= (count_q == '1) ? count_q : count_q + CW'(1);
				active_q <= sts.active;
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
				rd_ptr_q <= (wr_ptr_q == '0) ? PTR_W'(DEPTH - 1) : wr_ptr_q - PTR_W'(1);
				sum_q    <= '0;
			end else if (cmd.op == aass_pkg::OP_SWEEP) begin
				if (rd_en) begin
					rd_ptr_q <= (rd_ptr_q == '0) ? PTR_W'(DEPTH - 1) : rd_ptr_q - PTR_W'(1);
				end
				if (step_q != '0) begin
					sum_q <= sum_q + SUM_W'(sw_diff);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q <= price;
			prev_q  <= price;
		end else if (cmd.op == aass_pkg::OP_SWEEP && step_q != '0) begin
			prev_q <= rd_data_q;
			if (last) begin
				dir_q <= dir_c;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		unique case (cmd.sel)
			aass_pkg::SEL_FAST: n_sel = fast_q;
			aass_pkg::SEL_SLOW: n_sel = slow_q;
			default:            n_sel = emap_q;
		endcase
		n_eff = (n_sel == '0) ? aass_pkg::PERIOD_W'(1) : n_sel;
		np1   = CW'(n_eff) + CW'(1);
		if (cmd.sel == aass_pkg::SEL_ER) begin
			div_top = SUM_W'(dir_q);
			div_lo  = '0;
			div_v   = sum_q;
		end else begin
			div_top = SUM_W'(2);
			div_lo  = FW'(np1 >> 1);
			div_v   = SUM_W'(np1);
		end
		ge0    = div_top >= div_v;
		div_t  = {rem_q, lo_q[FW-1]};
		ge     = div_t >= {1'b0, div_v};
		q_next = {quo_q[Q_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (cmd.op == aass_pkg::OP_DIV) begin
			if (step_q == '0) begin
				rem_q <= ge0 ? div_top - div_v : div_top;
				quo_q <= Q_W'(ge0);
				lo_q  <= div_lo;
			end else begin
				rem_q <= ge ? SUM_W'(div_t - {1'b0, div_v}) : div_t[SUM_W-1:0];
				quo_q <= q_next;
				lo_q  <= lo_q << 1;
			end
			if (last) begin
				unique case (cmd.sel)
					aass_pkg::SEL_ER:   er_q     <= (sum_q == '0) ? '0 : q_next;
					aass_pkg::SEL_FAST: fast_r_q <= q_next;
					aass_pkg::SEL_SLOW: slow_r_q <= q_next;
					default:            ema_r_q  <= q_next;
				endcase
			end
		end
	end

	// blend a*w + b*(1-w), 24-bit limbs through one multiplier
	always_comb begin
		unique case (cmd.sel)
			aass_pkg::SEL_SSC: begin
				a_sel = LW'(fast_r_q);
				b_sel = LW'(slow_r_q);
				w_sel = er_q;
			end
			aass_pkg::SEL_C2: begin
				a_sel = LW'(ssc_q);
				b_sel = '0;
				w_sel = ssc_q;
			end
			aass_pkg::SEL_ADA: begin
				a_sel = {price_q, 16'd0};
				b_sel = ada_q;
				w_sel = c2_q;
			end
			default: begin
				a_sel = ada_q;
				b_sel = ema_q;
				w_sel = ema_r_q;
			end
		endcase
		v_sel = (Q_W'(1) << FW) - w_sel;
		unique case (step_q[1:0])
			2'd0: begin
				mul_x = a_sel[FW-1:0];
				mul_y = w_sel;
			end
			2'd1: begin
				mul_x = b_sel[FW-1:0];
				mul_y = v_sel;
			end
			2'd2: begin
				mul_x = a_sel[LW-1:FW];
				mul_y = w_sel;
			end
			default: begin
				mul_x = b_sel[LW-1:FW];
				mul_y = v_sel;
			end
		endcase
		prod_c  = mul_x * mul_y;
		mac_res = acc_q[FW +: LW];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == aass_pkg::OP_MAC) begin
			prod_q <= prod_c;
			if (step_q == '0) begin
				acc_q <= ACC_W'(1) << (FW - 1);
			end else if (step_q <= STEP_W'(2)) begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end else if (step_q <= STEP_W'(4)) begin
				acc_q <= acc_q + (ACC_W'(prod_q) << FW);
			end
			if (last) begin
				if (cmd.sel == aass_pkg::SEL_SSC) ssc_q <= mac_res[Q_W-1:0];
				if (cmd.sel == aass_pkg::SEL_C2)  c2_q  <= mac_res[Q_W-1:0];
			end
		end
	end

	// result and slope
	always_comb begin
		emap_eff = (emap_q == '0) ? aass_pkg::PERIOD_W'(1) : emap_q;
		e_c      = idx_q - CW'(w_eff);
		show     = active_q && (e_c >= CW'(emap_eff));
		rnd      = (LW + 1)'(ema_q) + (LW + 1)'(16'h8000);
		if (!show) begin
			avg_c = '0;
		end else if (rnd[LW]) begin
			avg_c = '1;
		end else begin
			avg_c = rnd[LW-1:16];
		end
		slope_c = $signed({1'b0, avg_c}) - $signed({1'b0, pavg_q});
		vol_c   = '0;
		if (oen_q) begin
			if (slope_c > 0) begin
				vol_c = (pslope_q > 0) ? 3'sd0 : ((pslope_q == 0) ? 3'sd1 : 3'sd2);
			end else if (slope_c < 0) begin
				vol_c = (pslope_q < 0) ? 3'sd0 : ((pslope_q == 0) ? -3'sd1 : -3'sd2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ada_q    <= '0;
			ema_q    <= '0;
			pavg_q   <= '0;
			have_q   <= 1'b0;
			pslope_q <= '0;
		end else begin
			if (cmd.op == aass_pkg::OP_MAC && last) begin
				if (cmd.sel == aass_pkg::SEL_ADA) ada_q <= mac_res;
				if (cmd.sel == aass_pkg::SEL_EMA) ema_q <= mac_res;
			end
			if (cmd.finish) begin
				if (active_q && e_c == '0) begin
					ada_q <= {price_q, 16'd0};
					ema_q <= {price_q, 16'd0};
				end
				pavg_q <= avg_c;
				have_q <= avg_c != '0;
				if (have_q) begin
					pslope_q <= slope_c;
				end
			end
			if (cfg_we && cfg_index == aass_pkg::REG_ORDER) begin
				pslope_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			average     <= avg_c;
			slope       <= have_q ? slope_c : '0;
			slope_valid <= have_q;
			order_size  <= have_q ? vol_c : '0;
		end
	end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for the adaptive average slope signal block
`timescale 1ns / 1ps
module tb_top;

	localparam int RING_N = 66;
	localparam int LIMIT  = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [aass_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [aass_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [aass_pkg::PRICE_WIDTH-1:0] price = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [aass_pkg::PRICE_WIDTH-1:0] average;
	logic signed [aass_pkg::SLOPE_W-1:0] slope;
	logic slope_valid;
	logic signed [aass_pkg::VOL_W-1:0] order_size;

	adaptive_average_slope_signal u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .price(price),
		.out_valid(out_valid), .out_ready(out_ready), .average(average), .slope(slope),
		.slope_valid(slope_valid), .order_size(order_size)
	);

	typedef struct packed {
		logic [aass_pkg::PRICE_WIDTH-1:0] avg;
		logic [aass_pkg::SLOPE_W-1:0] slp;
		logic vld;
		logic [aass_pkg::VOL_W-1:0] vol;
	} signal_t;

	// predictor state
	logic [9:0] p_fast = 10'd2, p_slow = 10'd30, p_ema = 10'd10;
	logic [6:0] p_win = 7'd10;
	logic p_order = 1'b0;
	logic [31:0] ring [RING_N];
	int unsigned wptr = 0, count = 0;
	logic [47:0] ada_lvl = '0, ema_lvl = '0;
	logic [31:0] prev_avg = '0;
	logic have_prev = 1'b0;
	longint prev_slope = 0;

	logic [31:0] price_q[$];
	signal_t expected_q[$];
	int mismatches = 0, cycles = 0, results = 0, valid_slopes = 0, orders_seen = 0;
	bit in_gaps = 1'b1, out_gaps = 1'b1, hold_in = 1'b0;

	function automatic longint unsigned rate(input logic [9:0] n);
		longint unsigned m;
		m = (n == 0) ? 1 : n;
		return ((64'd1 << 25) + (m + 1) / 2) / (m + 1);
	endfunction

	function automatic longint unsigned mix(input longint unsigned a, b, w);
		longint unsigned v, m, t0, t1, t2;
		m = (64'd1 << 24) - 1;
		v = (64'd1 << 24) - w;
		t0 = (a & m) * w + (b & m) * v;
		t1 = ((a >> 24) & m) * w + ((b >> 24) & m) * v;
		t2 = (a >> 48) * w + (b >> 48) * v;
		return t1 + (t2 << 24) + ((t0 + (64'd1 << 23)) >> 24);
	endfunction

	function automatic longint unsigned efficiency(input longint unsigned d, s);
		longint unsigned q, r;
		if (s == 0) return 0;
		q = (d >= s) ? 1 : 0;
		r = q ? d - s : d;
		for (int i = 0; i < 24; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= s) begin
				r = r - s;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned abs_move(input longint unsigned a, b);
		return a > b ? a - b : b - a;
	endfunction

	task automatic predict_signal(input logic [31:0] px);
		int unsigned idx, cur, w, e;
		longint unsigned msum, er, ssc, c2, avg, pl;
		longint sl;
		int vol;
		bit vld;
		signal_t r;
		idx = count; cur = wptr; avg = 0; sl = 0; vol = 0; vld = 0;
		ring[cur] = px;
		wptr = (cur + 1) % RING_N;
		if (count < 2047) count++;
		w = p_win;
		if (w < 1) w = 1;
		if (w > 64) w = 64;
		if (idx >= w) begin
			e = idx - w;
			msum = 0;
			for (int k = 0; k < w; k++)
				msum += abs_move(ring[(cur + RING_N - k) % RING_N],
					ring[(cur + RING_N - k - 1) % RING_N]);
			er = efficiency(abs_move(px, ring[(cur + RING_N - w) % RING_N]), msum);
			ssc = (er * rate(p_fast) + ((64'd1 << 24) - er) * rate(p_slow)
				+ (64'd1 << 23)) >> 24;
			c2 = (ssc * ssc + (64'd1 << 23)) >> 24;
			pl = longint'(px) << 16;
			if (e == 0) begin
				ada_lvl = pl;
				ema_lvl = pl;
			end else begin
				ada_lvl = mix(pl, ada_lvl, c2);
				ema_lvl = mix(ada_lvl, ema_lvl, rate(p_ema));
			end
			if (e >= ((p_ema == 0) ? 1 : p_ema)) begin
				avg = (longint'(ema_lvl) + 64'h8000) >> 16;
				if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
			end
		end
		if (have_prev) begin
			sl = longint'(avg) - longint'(prev_avg);
			vld = 1;
			if (p_order) begin
				if (sl > 0) vol = prev_slope > 0 ? 0 : (prev_slope == 0 ? 1 : 2);
				else if (sl < 0) vol = prev_slope < 0 ? 0 : (prev_slope == 0 ? -1 : -2);
			end
			prev_slope = sl;
		end
		prev_avg = avg[31:0];
		have_prev = (avg != 0);
		r.avg = avg[31:0];
		r.slp = sl[aass_pkg::SLOPE_W-1:0];
		r.vld = vld;
		r.vol = vol[aass_pkg::VOL_W-1:0];
		expected_q = {expected_q, r};
	endtask

	initial forever #5 clk = ~clk;

	always @(posedge clk) cycles <= cycles + 1;

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_signal(price);
				if (price_q.size() > 0 && !hold_in && !(in_gaps && $urandom_range(99) < 13))
					price <= price_q.pop_front();
				else
					in_valid <= 1'b0;
			end else if (!in_valid && price_q.size() > 0 && !hold_in
				&& !(in_gaps && $urandom_range(99) < 13)) begin
				in_valid <= 1'b1;
				price <= price_q.pop_front();
			end
			out_ready <= !(out_gaps && $urandom_range(99) < 13);
		end
	end

	// monitor
	always @(posedge clk) begin
		signal_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {average, slope, slope_valid, order_size};
			results++;
			if (slope_valid) valid_slopes++;
			if (order_size != 0) orders_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic write_reg(input logic [aass_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[aass_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aass_pkg::REG_FAST:   p_fast = val[9:0];
			aass_pkg::REG_SLOW:   p_slow = val[9:0];
			aass_pkg::REG_WINDOW: p_win = val[6:0];
			aass_pkg::REG_EMA:    p_ema = val[9:0];
			aass_pkg::REG_ORDER: begin
				p_order = val[0];
				prev_slope = 0;
			end
			default: ;
		endcase
	endtask

	task automatic drain();
		while (price_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] next_price(input logic [31:0] p);
		int d;
		case ($urandom_range(9))
			0: return $urandom;
			1: return p;
			default: begin
				d = $urandom_range(4000) - 2000;
				return p + d;
			end
		endcase
	endfunction

	task automatic random_phase(input int n, input logic [31:0] base);
		logic [31:0] p;
		p = base;
		for (int i = 0; i < n; i++) begin
			p = next_price(p);
			price_q = {price_q, p};
		end
	endtask

	initial begin
		logic [31:0] directed [20];
		directed = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'hAAAA_5555, 32'h5555_AAAA,
			32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, flat prices, short window, orders on
		write_reg(aass_pkg::REG_WINDOW, 2);
		write_reg(aass_pkg::REG_EMA, 1);
		write_reg(aass_pkg::REG_ORDER, 1);
		foreach (directed[i])
			price_q = {price_q, directed[i]};
		drain();
		// zero period and zero window act as one; window over max saturates
		write_reg(aass_pkg::REG_FAST, 0);
		write_reg(aass_pkg::REG_SLOW, 0);
		write_reg(aass_pkg::REG_WINDOW, 0);
		write_reg(aass_pkg::REG_EMA, 0);
		random_phase(60, 32'h0010_0000);
		drain();
		write_reg(aass_pkg::REG_FAST, 1023);
		write_reg(aass_pkg::REG_SLOW, 1023);
		write_reg(aass_pkg::REG_WINDOW, 127);
		write_reg(aass_pkg::REG_EMA, 1023);
		write_reg(aass_pkg::REG_ORDER, 0);
		random_phase(120, 32'h8000_0000);
		drain();
		write_reg(aass_pkg::REG_WINDOW, 64);
		write_reg(aass_pkg::REG_EMA, 3);
		write_reg(aass_pkg::REG_ORDER, 1);
		random_phase(150, $urandom);
		drain();
		// long stretch without idling on either side
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		write_reg(aass_pkg::REG_FAST, 2);
		write_reg(aass_pkg::REG_SLOW, 30);
		write_reg(aass_pkg::REG_WINDOW, 10);
		write_reg(aass_pkg::REG_EMA, 10);
		random_phase(300, 32'h0064_0000);
		drain();
		in_gaps = 1'b1;
		out_gaps = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(aass_pkg::REG_FAST, $urandom_range(1, 20));
			write_reg(aass_pkg::REG_SLOW, $urandom_range(20, 1023));
			write_reg(aass_pkg::REG_WINDOW, $urandom_range(1, 16));
			write_reg(aass_pkg::REG_EMA, $urandom_range(1, 12));
			write_reg(aass_pkg::REG_ORDER, $urandom_range(1));
			random_phase(100, $urandom);
			// sender waits for everything outstanding midway
			hold_in = 1'b1;
			while (in_valid || expected_q.size() > 0) @(posedge clk);
			hold_in = 1'b0;
			random_phase(120, $urandom);
			drain();
		end
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("covered %0d results, %0d with valid slope, %0d nonzero orders",
				results, valid_slopes, orders_seen);
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches,
				expected_q.size());
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
